@@ hw/rtl/wtsc_pkg.sv @@
// ----------------------------------------------------------------------------
// wtsc_pkg
// Shared types and constants for the wave-table sound channel.
// ----------------------------------------------------------------------------
`default_nettype none

package wtsc_pkg;

    // Table geometry: two banks of packed 4-bit samples.
    localparam int BANK_BYTES = 16;
    localparam int NUM_BANKS  = 2;
    localparam int TABLE_DEPTH = NUM_BANKS * BANK_BYTES;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int BYTE_AW     = $clog2(BANK_BYTES);
    localparam int PERIOD_W    = 14;
    localparam int CYCLES_W    = 10;
    localparam int FREQ_W      = 11;

    // Operation codes carried on the input beat.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_WRITE   = 2'd2;
    localparam logic [1:0] OP_INIT    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_TWO_BANK = 3'd1;
    localparam logic [2:0] CFG_FREQ     = 3'd2;
    localparam logic [2:0] CFG_VOLUME   = 3'd3;
    localparam logic [2:0] CFG_DAC      = 3'd4;
    localparam logic [2:0] CFG_ENABLE   = 3'd5;

    // Machine modes.
    localparam logic [1:0] MODE_ORIGINAL = 2'd0;
    localparam logic [1:0] MODE_COLOUR   = 2'd1;
    localparam logic [1:0] MODE_ADVANCE  = 2'd2;

    // Pattern bytes that unwritten bank 0 entries read as after init in colour mode.
    localparam logic [7:0] PATTERN_EVEN = 8'h00;
    localparam logic [7:0] PATTERN_ODD  = 8'hFF;

    // Configuration register set.
    typedef struct packed {
        logic [1:0]        mode;
        logic              two_bank;
        logic [FREQ_W-1:0] freq;
        logic [1:0]        volume;
        logic              dac_on;
        logic              enabled;
    } cfg_t;

    // Per-item information that travels alongside the table read.
    typedef struct packed {
        logic       advanced;   // tick reloaded the period
        logic       init;       // init item, output goes to zero
        logic       gate;       // converter and channel both on
        logic       low_nib;    // odd position selects the low nibble
        logic       hit;        // entry written since the last init
        logic [7:0] dflt_byte;  // value of an entry not written since init
    } rd_info_t;

endpackage : wtsc_pkg

`default_nettype wire

@@ hw/rtl/wave_table_sound_channel.sv @@
// ----------------------------------------------------------------------------
// wave_table_sound_channel
// Wave-table sound channel with a two-bank sample table.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one item per beat: tick, trigger, table byte write
//   or init, selected by s_tuser. Every item yields exactly one beat on the
//   m_ channel holding the channel output level and an advance flag.
//   The cfg channel writes the six setup registers by index; it is always
//   ready. The user must write it only while no item is in flight; the
//   block does not enforce this. An accepted s_ beat passes through the
//   registered read of the sample table and then the output register.
//   Throughput is one item per cycle while the receiver does not stall, set
//   by the single table read port and the period update.
//   When the receiver stalls, the output register holds its beat and the
//   read stage takes one further item; then s_tready drops until the output
//   drains.
//   Reset is synchronous and active low. It clears the control, setup and valid
//   registers but not the output payload, and marks every table entry unwritten,
//   so the table reads as zeros at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module wave_table_sound_channel
    import wtsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [9:0] cycles, [10] bank, [14:11] byte_index, [22:15] byte_value
    input  wire logic [23:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    // Result items.
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [3:0] sample
    output      logic [7:0]  m_tdata,
    // [0] advanced
    output      logic        m_tuser,
    // Configuration writes.
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    rd_info_t info;

    logic                s_accept;
    logic                s1_valid_reg, s1_valid_next;
    logic                move;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_sample_reg;
    logic                out_adv_reg;
    logic [3:0]          held_reg, held_next;

    logic                ram_we, ram_re;
    logic [TABLE_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    logic [7:0]          rd_byte;
    logic [3:0]          nibble;
    logic [3:0]          shaped;

    // Handshakes.
    assign move      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || move;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration register decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:     cfg_next.mode     = cfg_data[1:0];
                CFG_TWO_BANK: cfg_next.two_bank = cfg_data[0];
                CFG_FREQ:     cfg_next.freq     = cfg_data[FREQ_W-1:0];
                CFG_VOLUME:   cfg_next.volume   = cfg_data[1:0];
                CFG_DAC:      cfg_next.dac_on   = cfg_data[0];
                CFG_ENABLE:   cfg_next.enabled  = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front stage and sample table.
    wtsc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .operation  (s_tuser),
        .cycles     (s_tdata[9:0]),
        .bank       (s_tdata[10]),
        .byte_index (s_tdata[14:11]),
        .byte_value (s_tdata[22:15]),
        .cfg        (cfg_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .info_reg   (info)
    );

    wtsc_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sample shaping: pick the nibble and apply the volume shift.
    assign rd_byte = info.hit ? ram_rdata : info.dflt_byte;
    assign nibble  = info.low_nib ? rd_byte[3:0] : rd_byte[7:4];

    always_comb begin
        case (cfg_reg.volume)
            2'd1:    shaped = nibble;
            2'd2:    shaped = nibble >> 1;
            2'd3:    shaped = nibble >> 2;
            default: shaped = '0;
        endcase
    end

    // Held output updates as the item leaves the read stage.
    always_comb begin
        held_next = held_reg;
        if (move) begin
            if (info.init) begin
                held_next = '0;
            end else if (info.advanced) begin
                held_next = info.gate ? shaped : 4'd0;
            end
        end
    end

    // Read-stage and output valid flags.
    assign s1_valid_next  = s_accept || (s1_valid_reg && !move);
    assign out_valid_next = move || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (move) begin
            out_sample_reg <= held_next;
            out_adv_reg    <= info.advanced;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_sample_reg};
    assign m_tuser  = out_adv_reg;

endmodule : wave_table_sound_channel

`default_nettype wire

@@ hw/rtl/wtsc_ram.sv @@
// ----------------------------------------------------------------------------
// wtsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : wtsc_ram

`default_nettype wire

@@ hw/rtl/wtsc_seq.sv @@
// ----------------------------------------------------------------------------
// wtsc_seq
// Front stage: period counter, sample position and bank state, table
// write and read issue, and the per-entry written marks.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsc_seq
    import wtsc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [1:0]          operation,
    input  wire logic [CYCLES_W-1:0] cycles,
    input  wire logic                bank,
    input  wire logic [BYTE_AW-1:0]  byte_index,
    input  wire logic [7:0]          byte_value,
    input  wire cfg_t                cfg,
    output      logic                ram_we,
    output      logic [TABLE_AW-1:0] ram_waddr,
    output      logic [7:0]          ram_wdata,
    output      logic                ram_re,
    output      logic [TABLE_AW-1:0] ram_raddr,
    output      rd_info_t            info_reg
);

    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [4:0]             pos_reg, pos_next;
    logic                   bank_reg, bank_next;
    logic [TABLE_DEPTH-1:0] written_reg, written_next;
    logic                   pattern_reg, pattern_next;
    rd_info_t               info_next;

    logic signed [PERIOD_W:0] diff;
    logic                     fire;
    logic [PERIOD_W-1:0]      reload;
    logic [FREQ_W:0]          span;
    logic [4:0]               adv_pos;
    logic                     adv_bank;
    logic                     rd_bank;

    // Period arithmetic: subtract elapsed cycles, reload from frequency.
    assign diff   = $signed({1'b0, period_reg}) -
                    $signed({{(PERIOD_W-CYCLES_W+1){1'b0}}, cycles});
    assign fire   = diff[PERIOD_W] || (diff == '0);
    assign span   = {1'b1, {FREQ_W{1'b0}}} - {1'b0, cfg.freq};
    assign reload = {{(PERIOD_W-FREQ_W-2){1'b0}}, span, 1'b0};

    // Position and bank after an advance; the bank flips on wrap when two banks are on.
    assign adv_pos  = pos_reg + 5'd1;
    assign adv_bank = bank_reg ^ (cfg.two_bank && (pos_reg == 5'h1f));
    assign rd_bank  = (cfg.mode == MODE_ADVANCE) ? adv_bank : 1'b0;

    // Table ports.
    assign ram_we    = accept && (operation == OP_WRITE);
    assign ram_waddr = {bank, byte_index};
    assign ram_wdata = byte_value;
    assign ram_re    = accept && (operation == OP_TICK) && fire;
    assign ram_raddr = {rd_bank, adv_pos[4:1]};

    // Next-state decode of the accepted item.
    always_comb begin
        period_next  = period_reg;
        pos_next     = pos_reg;
        bank_next    = bank_reg;
        written_next = written_reg;
        pattern_next = pattern_reg;
        info_next    = info_reg;
        if (accept) begin
            info_next.advanced  = 1'b0;
            info_next.init      = 1'b0;
            info_next.gate      = cfg.dac_on && cfg.enabled;
            info_next.low_nib   = adv_pos[0];
            info_next.hit       = written_reg[ram_raddr];
            info_next.dflt_byte = (pattern_reg && !ram_raddr[TABLE_AW-1] && ram_raddr[0])
                                  ? PATTERN_ODD : PATTERN_EVEN;
            unique case (operation)
                OP_TICK: begin
                    if (fire) begin
                        period_next        = reload;
                        pos_next           = adv_pos;
                        bank_next          = adv_bank;
                        info_next.advanced = 1'b1;
                    end else begin
                        period_next = diff[PERIOD_W-1:0];
                    end
                end
                OP_TRIGGER: begin
                    pos_next = '0;
                end
                OP_WRITE: begin
                    written_next[ram_waddr] = 1'b1;
                end
                OP_INIT: begin
                    period_next    = '0;
                    pos_next       = '0;
                    bank_next      = 1'b0;
                    written_next   = '0;
                    pattern_next   = (cfg.mode == MODE_COLOUR);
                    info_next.init = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state; reset clears the table to zeros through the marks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= '0;
            pos_reg     <= '0;
            bank_reg    <= 1'b0;
            written_reg <= '0;
            pattern_reg <= 1'b0;
        end else begin
            period_reg  <= period_next;
            pos_reg     <= pos_next;
            bank_reg    <= bank_next;
            written_reg <= written_next;
            pattern_reg <= pattern_next;
        end
    end

    // Item information, aligned with the registered table read.
    always_ff @(posedge aclk) begin
        info_reg <= info_next;
    end

endmodule : wtsc_seq

`default_nettype wire

@@ hw/rtl/wtsc_checker.sv @@
// ----------------------------------------------------------------------------
// wtsc_checker
// Port-level checks of the wave-table sound channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tuser
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input backpressure only arises from a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled output");

    // An item accepted while no result is pending reaches the output when the receiver does not stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid ##1 m_tready |=> m_tvalid)
        else $error("result beat missing after an accepted item");

    // The padding bits of the result data stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'd0)
        else $error("result padding not zero");

endmodule : wtsc_checker

bind wave_table_sound_channel wtsc_checker u_wtsc_checker (.*);

`default_nettype wire

@@ tb/wave_table_sound_channel_tb.sv @@
// ----------------------------------------------------------------------------
// wave_table_sound_channel_tb
// Self-checking bench for the wave-table sound channel. A queue-fed driver
// sends item beats in random bursts. A monitor checks each result beat
// against a local model of the period counter, the sample position, the bank
// toggle and the two-bank sample table. The channel setup is rewritten
// between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module wave_table_sound_channel_tb
    import wtsc_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 42;

    // One input item as the driver sends it.
    typedef struct {
        logic [1:0] op;
        logic [9:0] cycles;
        logic       bank;
        logic [3:0] idx;
        logic [7:0] value;
    } chan_item_t;

    // One expected result beat.
    typedef struct {
        logic [3:0] sample;
        logic       advanced;
    } chan_level_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_MODE;
    logic [10:0] cfg_data = '0;

    // Model copy of the setup registers.
    logic [1:0]        set_mode;
    logic              set_two_bank;
    logic [FREQ_W-1:0] set_freq;
    logic [1:0]        set_volume;
    logic              set_dac;
    logic              set_enable;

    // Model copy of the channel state.
    logic [7:0] wave_bytes [TABLE_DEPTH];
    int         period_left;
    logic [4:0] play_pos;
    logic       play_bank;
    logic [3:0] out_level;

    chan_item_t  items_to_send [$];
    chan_level_t levels_due [$];

    int errors;
    int items_sent;
    int levels_seen;
    int advances;
    int bank_toggles;
    int setups;
    int burst_left;
    int gap_left;
    int quiet_cycles;
    int stall_kind;
    int stall_timer;
    int stall_phase;

    wave_table_sound_channel dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Clears the channel state, as reset and init do.
    function automatic void clear_channel();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            wave_bytes[k] = 8'h00;
        end
        period_left = 0;
        play_pos    = '0;
        play_bank   = 1'b0;
        out_level   = '0;
    endfunction

    // Applies one item to the model state and returns the level it produces.
    function automatic chan_level_t channel_step(input logic [1:0] op,
                                                 input logic [9:0] cycles,
                                                 input logic bank,
                                                 input logic [3:0] idx,
                                                 input logic [7:0] value);
        chan_level_t lvl;
        logic        rd_bank;
        logic [7:0]  rd_byte;
        logic [3:0]  nib;
        lvl.advanced = 1'b0;
        case (op)
            OP_TICK: begin
                period_left = period_left - int'(cycles);
                if (period_left <= 0) begin
                    if (set_two_bank && play_pos == 5'd31) begin
                        play_bank = ~play_bank;
                        bank_toggles++;
                    end
                    play_pos = play_pos + 5'd1;
                    rd_bank  = (set_mode == MODE_ADVANCE) ? play_bank : 1'b0;
                    rd_byte  = wave_bytes[{rd_bank, play_pos[4:1]}];
                    nib      = play_pos[0] ? rd_byte[3:0] : rd_byte[7:4];
                    if (!(set_dac && set_enable) || set_volume == 2'd0) begin
                        out_level = 4'd0;
                    end else begin
                        out_level = nib >> (set_volume - 2'd1);
                    end
                    period_left  = (2048 - int'(set_freq)) * 2;
                    lvl.advanced = 1'b1;
                end
            end
            OP_TRIGGER: begin
                play_pos = '0;
            end
            OP_WRITE: begin
                wave_bytes[{bank, idx}] = value;
            end
            default: begin
                clear_channel();
                // Colour mode preloads bank 0 with alternating bytes.
                if (set_mode == MODE_COLOUR) begin
                    for (int k = 0; k < BANK_BYTES; k++) begin
                        wave_bytes[k] = k[0] ? PATTERN_ODD : PATTERN_EVEN;
                    end
                end
            end
        endcase
        lvl.sample = out_level;
        return lvl;
    endfunction

    // Driver: sends queued items in bursts with random gaps between them.
    always @(posedge aclk) begin : item_driver
        chan_item_t it;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                levels_due.push_back(channel_step(s_tuser, s_tdata[9:0], s_tdata[10],
                                                  s_tdata[14:11], s_tdata[22:15]));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    it = items_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.op;
                    s_tdata  <= {1'b0, it.value, it.idx, it.bank, it.cycles};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: the ready pattern switches between several stall styles.
    always @(posedge aclk) begin : level_sink
        if (stall_timer == 0) begin
            stall_kind  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        stall_phase++;
        case (stall_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_phase % 5) < 3;
        endcase
    end

    // Monitor: checks each result beat against the oldest expected level.
    always @(posedge aclk) begin : level_monitor
        chan_level_t want;
        if (aresetn && m_tvalid && m_tready) begin
            levels_seen++;
            if (levels_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected: sample %0d advanced %0b",
                         $time, m_tdata[3:0], m_tuser);
            end else begin
                want = levels_due.pop_front();
                if (m_tdata[3:0] !== want.sample) begin
                    errors++;
                    $display("%0t: sample mismatch: expected %0d, got %0d",
                             $time, want.sample, m_tdata[3:0]);
                end
                if (m_tuser !== want.advanced) begin
                    errors++;
                    $display("%0t: advanced mismatch: expected %0b, got %0b",
                             $time, want.advanced, m_tuser);
                end
                if (want.advanced) begin
                    advances++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Waits until every item has been sent and every level has come back.
    task automatic wait_idle();
        while (items_to_send.size() != 0 || s_tvalid || levels_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Writes all six setup registers and mirrors them in the model.
    task automatic apply_setup(input logic [1:0] mode, input logic two_bank,
                               input logic [10:0] freq, input logic [1:0] volume,
                               input logic dac, input logic enable);
        logic [2:0]  idx [6];
        logic [10:0] val [6];
        idx = '{CFG_MODE, CFG_TWO_BANK, CFG_FREQ, CFG_VOLUME, CFG_DAC, CFG_ENABLE};
        val = '{{9'd0, mode}, {10'd0, two_bank}, freq, {9'd0, volume},
                {10'd0, dac}, {10'd0, enable}};
        @(posedge aclk);
        for (int k = 0; k < 6; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            case (idx[k])
                CFG_MODE:     set_mode     = val[k][1:0];
                CFG_TWO_BANK: set_two_bank = val[k][0];
                CFG_FREQ:     set_freq     = val[k];
                CFG_VOLUME:   set_volume   = val[k][1:0];
                CFG_DAC:      set_dac      = val[k][0];
                default:      set_enable   = val[k][0];
            endcase
        end
        cfg_valid <= 1'b0;
        setups++;
    endtask

    task automatic push_item(input logic [1:0] op, input logic [9:0] cycles,
                             input logic bank, input logic [3:0] idx,
                             input logic [7:0] value);
        chan_item_t it;
        it.op     = op;
        it.cycles = cycles;
        it.bank   = bank;
        it.idx    = idx;
        it.value  = value;
        items_to_send.push_back(it);
    endtask

    // Random item; tick-heavy phases sweep the position through its wrap.
    task automatic push_random(input bit sweep);
        int          pick;
        logic [1:0]  op;
        logic [9:0]  cycles;
        pick = $urandom_range(0, 99);
        if (sweep) begin
            op = (pick < 92) ? OP_TICK : OP_WRITE;
        end else if (pick < 60) begin
            op = OP_TICK;
        end else if (pick < 88) begin
            op = OP_WRITE;
        end else if (pick < 95) begin
            op = OP_TRIGGER;
        end else begin
            op = OP_INIT;
        end
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            cycles = 10'd0;
        end else if (pick < 6) begin
            cycles = 10'd1023;
        end else if (pick < 8) begin
            cycles = 10'($urandom_range(1, 3));
        end else begin
            cycles = 10'($urandom_range(0, 1023));
        end
        push_item(op, cycles, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    function automatic logic [10:0] pick_freq();
        case ($urandom_range(0, 5))
            0:       return 11'd0;
            1:       return 11'd2047;
            2:       return 11'd2046;
            3:       return 11'($urandom_range(1984, 2047));
            4:       return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(1800, 2047));
        endcase
    endfunction

    // Stimulus: reset, directed phases, then random phases.
    initial begin : stimulus
        bit sweep;
        set_mode     = '0;
        set_two_bank = 1'b0;
        set_freq     = '0;
        set_volume   = '0;
        set_dac      = 1'b0;
        set_enable   = 1'b0;
        clear_channel();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Colour mode: pattern load, zero-cycle advance, overshoot, writes, trigger.
        apply_setup(MODE_COLOUR, 1'b1, 11'd2047, 2'd1, 1'b1, 1'b1);
        push_item(OP_INIT,    10'd0,    1'b0, 4'd0,  8'h00);
        push_item(OP_TICK,    10'd0,    1'b0, 4'd0,  8'h00);
        push_item(OP_TICK,    10'd1023, 1'b1, 4'd15, 8'hFF);
        push_item(OP_TICK,    10'd1,    1'b0, 4'd0,  8'h00);
        push_item(OP_TICK,    10'd1,    1'b0, 4'd0,  8'h00);
        push_item(OP_WRITE,   10'd0,    1'b0, 4'd1,  8'h5A);
        push_item(OP_WRITE,   10'd1023, 1'b1, 4'd15, 8'hFF);
        push_item(OP_TICK,    10'd1023, 1'b0, 4'd0,  8'h00);
        push_item(OP_TRIGGER, 10'd1023, 1'b1, 4'd15, 8'hFF);
        push_item(OP_TICK,    10'd1023, 1'b0, 4'd0,  8'h00);
        push_item(OP_TICK,    10'd0,    1'b0, 4'd0,  8'h00);
        wait_idle();

        // Banked reads with the channel off and the longest period.
        apply_setup(MODE_ADVANCE, 1'b0, 11'd0, 2'd3, 1'b1, 1'b0);
        push_item(OP_WRITE, 10'd0, 1'b1, 4'd0, 8'hF7);
        for (int k = 0; k < 5; k++) begin
            push_item(OP_TICK, 10'd1023, 1'b0, 4'd0, 8'h00);
        end
        wait_idle();

        // Original mode, converter off, then init without the pattern.
        apply_setup(MODE_ORIGINAL, 1'b1, 11'd2046, 2'd2, 1'b0, 1'b1);
        push_item(OP_WRITE, 10'd0,    1'b0, 4'd0, 8'hF0);
        push_item(OP_TICK,  10'd1023, 1'b0, 4'd0, 8'h00);
        push_item(OP_INIT,  10'd1023, 1'b1, 4'd15, 8'hFF);
        push_item(OP_TICK,  10'd5,    1'b0, 4'd0, 8'h00);
        wait_idle();

        // Random phases; the first two use the extreme settings.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                apply_setup(MODE_ADVANCE, 1'b1, 11'd2047, 2'd3, 1'b1, 1'b1);
            end else if (p == 1) begin
                apply_setup(MODE_ORIGINAL, 1'b0, 11'd0, 2'd0, 1'b0, 1'b0);
            end else begin
                apply_setup(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                            pick_freq(), 2'($urandom_range(0, 3)),
                            $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            end
            sweep = (p == 0) || ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                push_random(sweep);
                // Hold the sender back once per phase until the output drains.
                if (k == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d items across %0d channel setups; %0d result beats checked.",
                 items_sent, setups, levels_seen);
        $display("Saw %0d period reloads and %0d bank toggles at the position wrap.",
                 advances, bank_toggles);
        if (errors == 0 && levels_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/wtsc_pkg.sv
hw/rtl/wtsc_ram.sv
hw/rtl/wtsc_seq.sv
hw/rtl/wave_table_sound_channel.sv
hw/rtl/wtsc_checker.sv
tb/wave_table_sound_channel_tb.sv
